/* rtl/spf_pkg.sv */
package spf_pkg;

  localparam int CX_W       = 14;   // center register width, signed
  localparam int PIX_W      = 12;   // pixel coordinate width, unsigned
  localparam int LUM_W      = 17;   // luminance width, unsigned Q16
  localparam int DX_W       = 15;   // center minus pixel, signed
  localparam int SQ_W       = 28;   // one square, max 12287^2
  localparam int S_W        = 29;   // sum of two squares
  localparam int SS_W       = 15;   // squared distance inside the radius
  localparam int RAD_W      = 32;   // sqrt radicand: s << 16
  localparam int ROOT_W     = 16;   // distance, 8 fraction bits
  localparam int REM_W      = 20;   // sqrt partial remainder
  localparam int SQRT_STAGES     = 8;
  localparam int STEPS_PER_STAGE = ROOT_W / SQRT_STAGES;
  localparam int DIST_FRAC_BITS  = 8;
  localparam int RATE_W     = 17;
  localparam int DPROD_W    = ROOT_W + RATE_W;
  localparam int DIM_SHIFT  = 24 - DIST_FRAC_BITS;
  localparam int LPROD_W    = 2 * LUM_W;

  localparam logic [S_W-1:0]    RADIUS_SQ = S_W'(25600);
  localparam logic [RATE_W-1:0] RATE_Q24  = RATE_W'(83886);
  localparam logic [LUM_W-1:0]  FAR_GAIN  = LUM_W'(13107);
  localparam logic [LUM_W-1:0]  ONE_Q16   = LUM_W'(65536);

  localparam int CFG_ADDR_W = 1;
  localparam logic [CFG_ADDR_W-1:0] REG_CENTER_X = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_CENTER_Y = 1'b1;

  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 24;

  typedef struct packed {
    logic [RAD_W-1:0]  rad;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    logic              in_radius;
    logic [LUM_W-1:0]  lum;
  } sqrt_ctx_t;

endpackage

/* rtl/spotlight_luminance_falloff_unit.sv */
// Radial spotlight falloff: each input word carries a pixel's column, row and Q16
// luminance; the output word is that luminance dimmed by 0.5% per pixel of distance
// from the configured center, or scaled by 0.2 at a distance of 160 pixels and beyond.
// The unit takes one word per clock while the output side does not stall and
// returns results in input order, through 3 stages for the squared distance,
// 8 stages of the square root (two root bits per stage) and 3 stages for the
// gain and the final multiply. Each stage holds its word on a stall and empty
// stages keep accepting. The center registers are written through the cfg port
// and should only change while no word is in flight.
module spotlight_luminance_falloff_unit import spf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CX_W-1:0]       cfg_wdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // pixel_x[11:0], pixel_y[23:12], lum_in[40:24]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata   // lum_out[16:0]
);

  logic signed [CX_W-1:0] center_x_r, center_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r <= '0;
      center_y_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_CENTER_X: center_x_r <= cfg_wdata;
        REG_CENTER_Y: center_y_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic       d_valid, d_ready;
  sqrt_ctx_t  d_ctx;
  logic       q_valid, q_ready;
  sqrt_ctx_t  q_ctx;
  logic [LUM_W-1:0] lum_out;

  spf_dist_sq u_dist (
    .clk       (clk),
    .rst_n     (rst_n),
    .center_x  (center_x_r),
    .center_y  (center_y_r),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .pixel_x   (in_tdata[0 +: PIX_W]),
    .pixel_y   (in_tdata[PIX_W +: PIX_W]),
    .lum_in    (in_tdata[2*PIX_W +: LUM_W]),
    .out_valid (d_valid),
    .out_ready (d_ready),
    .out_ctx   (d_ctx)
  );

  spf_isqrt u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (d_valid),
    .in_ready  (d_ready),
    .in_ctx    (d_ctx),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_ctx   (q_ctx)
  );

  spf_gain u_gain (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (q_valid),
    .in_ready  (q_ready),
    .in_ctx    (q_ctx),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .lum_out   (lum_out)
  );

  assign out_tdata = {{(OUT_DATA_W-LUM_W){1'b0}}, lum_out};

endmodule

/* rtl/spf_dist_sq.sv */
module spf_dist_sq import spf_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic signed [CX_W-1:0]  center_x,
  input  logic signed [CX_W-1:0]  center_y,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [PIX_W-1:0]        pixel_x,
  input  logic [PIX_W-1:0]        pixel_y,
  input  logic [LUM_W-1:0]        lum_in,
  output logic                    out_valid,
  input  logic                    out_ready,
  output sqrt_ctx_t               out_ctx
);

  // stage 1: differences
  logic                   v1_r;
  logic signed [DX_W-1:0] dx_r, dy_r;
  logic [LUM_W-1:0]       lum1_r;
  // stage 2: squares
  logic                   v2_r;
  logic [SQ_W-1:0]        sqx_r, sqy_r;
  logic [LUM_W-1:0]       lum2_r;
  // stage 3: sum and radius test
  logic                   v3_r;
  sqrt_ctx_t              ctx_r;

  logic rdy1, rdy2, rdy3;
  logic signed [DX_W-1:0]   dx_nxt, dy_nxt;
  logic signed [2*DX_W-1:0] sqx_full, sqy_full;
  logic [S_W-1:0]           s_sum;

  assign rdy3     = !v3_r || out_ready;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  assign dx_nxt = DX_W'(center_x) - $signed({{(DX_W-PIX_W){1'b0}}, pixel_x});
  assign dy_nxt = DX_W'(center_y) - $signed({{(DX_W-PIX_W){1'b0}}, pixel_y});

  assign sqx_full = dx_r * dx_r;
  assign sqy_full = dy_r * dy_r;

  assign s_sum = {1'b0, sqx_r} + {1'b0, sqy_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      dx_r   <= dx_nxt;
      dy_r   <= dy_nxt;
      lum1_r <= lum_in;
    end
    if (rdy2 && v1_r) begin
      sqx_r  <= sqx_full[SQ_W-1:0];
      sqy_r  <= sqy_full[SQ_W-1:0];
      lum2_r <= lum1_r;
    end
    if (rdy3 && v2_r) begin
      ctx_r.in_radius <= (s_sum < RADIUS_SQ);
      // radicand is s with 16 fraction bits; only meaningful inside the radius
      ctx_r.rad    <= {1'b0, s_sum[SS_W-1:0], {(RAD_W-SS_W-1){1'b0}}};
      ctx_r.rem    <= '0;
      ctx_r.root   <= '0;
      ctx_r.lum    <= lum2_r;
    end
  end

  assign out_valid = v3_r;
  assign out_ctx   = ctx_r;

endmodule

/* rtl/spf_isqrt.sv */
module spf_isqrt import spf_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  sqrt_ctx_t in_ctx,
  output logic      out_valid,
  input  logic      out_ready,
  output sqrt_ctx_t out_ctx
);

  // one digit-by-digit step: bring down two radicand bits, try root*4+1
  function automatic sqrt_ctx_t sqrt_step(input sqrt_ctx_t c);
    sqrt_ctx_t        n;
    logic [REM_W-1:0] r2;
    logic [REM_W-1:0] t;
    n  = c;
    r2 = {c.rem[REM_W-3:0], c.rad[RAD_W-1 -: 2]};
    t  = {{(REM_W-ROOT_W-2){1'b0}}, c.root, 2'b01};
    if (r2 >= t) begin
      n.rem  = r2 - t;
      n.root = {c.root[ROOT_W-2:0], 1'b1};
    end else begin
      n.rem  = r2;
      n.root = {c.root[ROOT_W-2:0], 1'b0};
    end
    n.rad = {c.rad[RAD_W-3:0], 2'b00};
    return n;
  endfunction

  logic      v_r   [SQRT_STAGES];
  sqrt_ctx_t ctx_r [SQRT_STAGES];
  logic      rdy   [SQRT_STAGES+1];

  assign rdy[SQRT_STAGES] = out_ready;
  assign in_ready         = rdy[0];

  for (genvar i = 0; i < SQRT_STAGES; i++) begin : g_stage
    logic      v_prev;
    sqrt_ctx_t c_prev;
    sqrt_ctx_t c_step [STEPS_PER_STAGE+1];

    if (i == 0) begin : g_first
      assign v_prev = in_valid;
      assign c_prev = in_ctx;
    end else begin : g_next
      assign v_prev = v_r[i-1];
      assign c_prev = ctx_r[i-1];
    end

    assign c_step[0] = c_prev;
    for (genvar k = 0; k < STEPS_PER_STAGE; k++) begin : g_step
      assign c_step[k+1] = sqrt_step(c_step[k]);
    end

    assign rdy[i] = !v_r[i] || rdy[i+1];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (rdy[i]) begin
        v_r[i] <= v_prev;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[i] && v_prev) begin
        ctx_r[i] <= c_step[STEPS_PER_STAGE];
      end
    end
  end

  assign out_valid = v_r[SQRT_STAGES-1];
  assign out_ctx   = ctx_r[SQRT_STAGES-1];

endmodule

/* rtl/spf_gain.sv */
module spf_gain import spf_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  sqrt_ctx_t        in_ctx,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [LUM_W-1:0] lum_out
);

  logic               v1_r, v2_r, v3_r;
  logic [DPROD_W-1:0] dprod_r;
  logic               inside1_r;
  logic [LUM_W-1:0]   lum1_r, lum2_r;
  logic [LUM_W-1:0]   gain_r;
  logic [LUM_W-1:0]   lum_out_r;

  logic rdy1, rdy2, rdy3;
  logic [DPROD_W-1:0] dprod_nxt;
  logic [LUM_W-1:0]   dim;
  logic [LUM_W-1:0]   gain_nxt;
  logic [LPROD_W-1:0] lprod;

  assign rdy3     = !v3_r || out_ready;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  assign dprod_nxt = {{RATE_W{1'b0}}, in_ctx.root} * {{ROOT_W{1'b0}}, RATE_Q24};

  // dim stays below 1.0 for any distance inside the radius
  assign dim      = dprod_r[DIM_SHIFT +: LUM_W];
  assign gain_nxt = inside1_r ? (ONE_Q16 - dim) : FAR_GAIN;

  assign lprod = {{LUM_W{1'b0}}, lum2_r} * {{LUM_W{1'b0}}, gain_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      dprod_r   <= dprod_nxt;
      inside1_r <= in_ctx.in_radius;
      lum1_r    <= in_ctx.lum;
    end
    if (rdy2 && v1_r) begin
      gain_r <= gain_nxt;
      lum2_r <= lum1_r;
    end
    if (rdy3 && v2_r) begin
      // gain never exceeds 1.0, so the result fits the input width
      lum_out_r <= lprod[16 +: LUM_W];
    end
  end

  assign out_valid = v3_r;
  assign lum_out   = lum_out_r;

endmodule

/* rtl/spf_checker.sv */
module spf_checker import spf_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  cfg_we,
  input logic [CFG_ADDR_W-1:0] cfg_addr,
  input logic [CX_W-1:0]       cfg_wdata,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic [IN_DATA_W-1:0]  in_tdata,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata
);

  // output word held until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output word dropped or changed while stalled");

  // a free output stage lets every earlier stage advance
  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tready || !out_tvalid) |-> in_tready)
    else $error("input stalled with a free pipeline");

  // pipeline is empty in the cycle after reset is sampled
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  // dimmed luminance never carries bits past the field
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[OUT_DATA_W-1:LUM_W] == '0)
    else $error("output padding not zero");

endmodule

bind spotlight_luminance_falloff_unit spf_checker u_spf_checker (.*);
